/* hdl/eopp_pkg.sv */
// ----------------------------------------------------------------------------
// eopp_pkg: shared types and constants for the exotic option path payoff unit
// Holds the transaction structs, option kinds, register indexes and widths.
// ----------------------------------------------------------------------------
package eopp_pkg;

  // Longest path whose samples still enter the sum and the count.
  localparam int MaxSteps = 4096;
  localparam int PriceW   = 32;
  localparam int SumW     = PriceW + $clog2(MaxSteps);
  localparam int CntW     = $clog2(MaxSteps + 1);
  localparam int KindW    = 3;
  localparam int CfgIdxW  = 2;

  typedef enum logic [KindW-1:0] {
    KIND_ASIAN_CALL = 3'd0,
    KIND_ASIAN_PUT  = 3'd1,
    KIND_DOWN_OUT   = 3'd2,
    KIND_UP_OUT     = 3'd3,
    KIND_LB_CALL    = 3'd4,
    KIND_LB_PUT     = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OPTION_KIND = 2'd0,
    CFG_STRIKE      = 2'd1,
    CFG_BARRIER     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PriceW-1:0] price;
    logic              path_first;
    logic              path_last;
  } in_t;

  typedef struct packed {
    logic [PriceW-1:0] payoff;
    logic              knocked_out;
    logic              bad_path;
  } out_t;

endpackage

/* hdl/eopp_div.sv */
// ----------------------------------------------------------------------------
// eopp_div: restoring divider for the path average
// Produces one quotient bit per cycle; pulses done when the quotient is ready.
// ----------------------------------------------------------------------------
module eopp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [eopp_pkg::SumW-1:0]    dividend_i,
  input  logic [eopp_pkg::CntW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [eopp_pkg::PriceW-1:0]  quotient_o
);
  import eopp_pkg::*;

  localparam int IterW = $clog2(SumW + 1);

  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dsr_q, dsr_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW:0]    trial;
  logic [CntW:0]    trial_diff;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial      = {rem_q, quo_q[SumW-1]};
  assign trial_diff = trial - {1'b0, dsr_q};
  assign fits       = (trial >= {1'b0, dsr_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      iter_d = IterW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[SumW-2:0], fits};
      rem_d  = fits ? trial_diff[CntW-1:0] : trial[CntW-1:0];
      iter_d = iter_q - 1'b1;
      if (iter_q == IterW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      iter_q <= iter_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  // The average never exceeds the largest sample, so the low bits hold it.
  assign done_o     = done_q;
  assign quotient_o = quo_q[PriceW-1:0];

endmodule

/* hdl/exotic_option_path_payoff_unit.sv */
// ----------------------------------------------------------------------------
// exotic_option_path_payoff_unit: per-path payoff for Monte Carlo option pricing
// Tracks sum, count, extremes and knock-out of one price path and emits the
// payoff of the configured exotic option kind when the path ends.
// ----------------------------------------------------------------------------
// Throughput: samples that do not end a path stream back to back at one per
// cycle while the unit is idle.
// A path-ending sample passes through CALC, then DIV for the Asian kinds when
// the count is not zero, where the bit-serial divider forms the average, and
// then DONE; no input transaction is taken meanwhile.
// Asynchronous active-low reset clears control, config and path state at once.
module exotic_option_path_payoff_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [eopp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [eopp_pkg::PriceW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  eopp_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output eopp_pkg::out_t                out_o
);
  import eopp_pkg::*;

  // Sequencer states. IDLE takes samples; CALC decides whether the average is
  // needed; DIV waits for the divider; DONE forms the payoff and hands it to
  // the output register as soon as that register is free.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  kind_e             kind_q;
  logic [PriceW-1:0] strike_q;
  logic [PriceW-1:0] barrier_q;

  // Path state.
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PriceW-1:0] min_q, min_d;
  logic [PriceW-1:0] max_q, max_d;
  logic              knock_q, knock_d;
  logic [PriceW-1:0] last_price_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  out_t              out_q;

  logic              in_accept;
  logic              hits;
  logic              clear_path;
  logic              out_free;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [PriceW-1:0] avg;
  logic [PriceW-1:0] op_a;
  logic [PriceW-1:0] op_b;
  logic [PriceW:0]   diff;
  logic [PriceW-1:0] pay;
  logic              is_asian;
  logic              knocked;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Configuration writes. Host must write only while unit is idle; unenforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_ASIAN_CALL;
      strike_q  <= '0;
      barrier_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OPTION_KIND: kind_q    <= kind_e'(cfg_wdata_i[KindW-1:0]);
        CFG_STRIKE:      strike_q  <= cfg_wdata_i;
        CFG_BARRIER:     barrier_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The barrier test uses the option kind in force when the sample arrives.
  assign hits = ((kind_q == KIND_DOWN_OUT) && (in_i.price <= barrier_q)) ||
                ((kind_q == KIND_UP_OUT)   && (in_i.price >= barrier_q));

  // Path state update. A loaded result clears it all. A path start reloads the
  // extremes from its own sample and empties the sum; later samples accumulate
  // until the count saturates at the step limit, while extremes and knock flag track.
  always_comb begin
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    min_d   = min_q;
    max_d   = max_q;
    knock_d = knock_q;
    if (clear_path) begin
      sum_d   = '0;
      cnt_d   = '0;
      min_d   = '1;
      max_d   = '0;
      knock_d = 1'b0;
    end else if (in_accept) begin
      if (in_i.path_first) begin
        sum_d   = '0;
        cnt_d   = '0;
        min_d   = in_i.price;
        max_d   = in_i.price;
        knock_d = hits;
      end else begin
        if (cnt_q < CntW'(MaxSteps)) begin
          sum_d = sum_q + SumW'(in_i.price);
          cnt_d = cnt_q + 1'b1;
        end
        if (in_i.price < min_q) min_d = in_i.price;
        if (in_i.price > max_q) max_d = in_i.price;
        if (hits) knock_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      min_q   <= '1;
      max_q   <= '0;
      knock_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      min_q   <= min_d;
      max_q   <= max_d;
      knock_q <= knock_d;
    end
  end

  // The final sample itself is needed for the barrier and lookback payoffs.
  always_ff @(posedge clk_i) begin
    if (in_accept) last_price_q <= in_i.price;
  end

  assign is_asian = (kind_q == KIND_ASIAN_CALL) || (kind_q == KIND_ASIAN_PUT);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && in_i.path_last) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (is_asian && (cnt_q != '0)) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  eopp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (avg)
  );

  // Payoff: pick the two operands for the kind, then one clamped subtract.
  always_comb begin
    case (kind_q)
      KIND_ASIAN_CALL: begin
        op_a = avg;
        op_b = strike_q;
      end
      KIND_ASIAN_PUT: begin
        op_a = strike_q;
        op_b = avg;
      end
      KIND_DOWN_OUT, KIND_UP_OUT: begin
        op_a = last_price_q;
        op_b = strike_q;
      end
      KIND_LB_CALL: begin
        op_a = last_price_q;
        op_b = min_q;
      end
      KIND_LB_PUT: begin
        op_a = max_q;
        op_b = last_price_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};

  // Unused kinds never report a knock-out.
  assign knocked = knock_q && (kind_q <= KIND_LB_PUT);

  always_comb begin
    pay = diff[PriceW] ? '0 : diff[PriceW-1:0];
    // A path with no sample after its start pays nothing, whatever the kind.
    if (cnt_q == '0) pay = '0;
    if (knocked && ((kind_q == KIND_DOWN_OUT) || (kind_q == KIND_UP_OUT))) pay = '0;
  end

  // Output register: a finished transaction may wait here while the next path
  // streams in; a new result only waits in DONE if the previous one is unread.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;
  assign clear_path = out_load;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.payoff      <= pay;
      out_q.knocked_out <= knocked;
      out_q.bad_path    <= (cnt_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hdl/eopp_chk.sv */
// ----------------------------------------------------------------------------
// eopp_chk: port-level checks for the exotic option path payoff unit
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module eopp_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input eopp_pkg::in_t                 in_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input eopp_pkg::out_t                out_o
);
  import eopp_pkg::*;

  logic in_accept;
  assign in_accept = in_valid_i && !in_stall_o;

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or was withdrawn");

  // A path-ending transaction makes the unit busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.path_last |=> in_stall_o)
    else $error("unit not busy after a path end");

  // Samples inside a path stream without stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_i.path_last |=> !in_stall_o)
    else $error("stall after a mid-path sample");

  // A new result only appears while the input side is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a path end");

  // A path without samples after its start pays nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.bad_path |-> out_o.payoff == '0)
    else $error("bad path with nonzero payoff");

endmodule

bind exotic_option_path_payoff_unit eopp_chk u_eopp_chk (.*);

/* tb/eopp_path_checker.sv */
// ----------------------------------------------------------------------------
// eopp_path_checker: payoff predictor and scoreboard for the path payoff unit
// Mirrors the register file and the path state from the observed port
// activity. It predicts one payoff per path-ending sample and compares every
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module eopp_path_checker
  import eopp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [PriceW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [KindW-1:0]  kind_q;
  logic [PriceW-1:0] strike_q;
  logic [PriceW-1:0] barrier_q;

  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   cnt_q;
  logic [PriceW-1:0] low_q;
  logic [PriceW-1:0] high_q;
  logic              knock_q;

  out_t expected_payoffs[$];

  function automatic logic [PriceW-1:0] clip_sub(logic [SumW-1:0] a, logic [SumW-1:0] b);
    return (a > b) ? PriceW'(a - b) : '0;
  endfunction

  function automatic logic barrier_hit(logic [PriceW-1:0] p);
    if (kind_q == KIND_DOWN_OUT) return p <= barrier_q;
    if (kind_q == KIND_UP_OUT) return p >= barrier_q;
    return 1'b0;
  endfunction

  function automatic out_t settle_path(logic [PriceW-1:0] s_t);
    out_t            res;
    logic [SumW-1:0] avg;
    logic            knocked;
    knocked         = knock_q && (kind_q <= KIND_LB_PUT);
    res.payoff      = '0;
    res.knocked_out = knocked;
    res.bad_path    = (cnt_q == 0);
    if (cnt_q != 0) begin
      avg = sum_q / cnt_q;
      case (kind_q)
        KIND_ASIAN_CALL: res.payoff = clip_sub(avg, strike_q);
        KIND_ASIAN_PUT:  res.payoff = clip_sub(strike_q, avg);
        KIND_DOWN_OUT,
        KIND_UP_OUT:     res.payoff = knocked ? '0 : clip_sub(s_t, strike_q);
        KIND_LB_CALL:    res.payoff = clip_sub(s_t, low_q);
        KIND_LB_PUT:     res.payoff = clip_sub(high_q, s_t);
        default:         res.payoff = '0;
      endcase
    end
    return res;
  endfunction

  function automatic void clear_path();
    sum_q   = '0;
    cnt_q   = '0;
    low_q   = '1;
    high_q  = '0;
    knock_q = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_t expect_q;
    out_t got;
    if (!rst_ni) begin
      kind_q       = '0;
      strike_q     = '0;
      barrier_q    = '0;
      clear_path();
      expected_payoffs.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OPTION_KIND: kind_q    = cfg_wdata_i[KindW-1:0];
          CFG_STRIKE:      strike_q  = cfg_wdata_i;
          CFG_BARRIER:     barrier_q = cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got = out_i;
        if (expected_payoffs.size() == 0) begin
          $error("result with no payoff pending: payoff %h knocked_out %b bad_path %b",
                 got.payoff, got.knocked_out, got.bad_path);
          fail_count_o++;
        end else begin
          expect_q = expected_payoffs.pop_front();
          if (got.payoff !== expect_q.payoff) begin
            $error("payoff: expected %h, got %h", expect_q.payoff, got.payoff);
            fail_count_o++;
          end
          if (got.knocked_out !== expect_q.knocked_out) begin
            $error("knocked_out: expected %b, got %b", expect_q.knocked_out, got.knocked_out);
            fail_count_o++;
          end
          if (got.bad_path !== expect_q.bad_path) begin
            $error("bad_path: expected %b, got %b", expect_q.bad_path, got.bad_path);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (in_i.path_first) begin
          clear_path();
          low_q   = in_i.price;
          high_q  = in_i.price;
          knock_q = barrier_hit(in_i.price);
        end else begin
          // Samples beyond the step limit still move the extremes and the knock.
          if (cnt_q < MaxSteps) begin
            sum_q = sum_q + in_i.price;
            cnt_q = cnt_q + 1'b1;
          end
          if (in_i.price < low_q) low_q = in_i.price;
          if (in_i.price > high_q) high_q = in_i.price;
          if (barrier_hit(in_i.price)) knock_q = 1'b1;
        end
        if (in_i.path_last) begin
          expected_payoffs.push_back(settle_path(in_i.price));
          clear_path();
        end
      end

      pending_o = expected_payoffs.size();
    end
  end

endmodule

/* tb/tb_exotic_option_path_payoff_unit.sv */
// ----------------------------------------------------------------------------
// tb_exotic_option_path_payoff_unit: stimulus and verdict for the payoff unit
// Drives directed paths for every option kind and corner, a path that runs
// past the step limit, and random configurations with random path traffic
// under random idling on both channels. The checker module does the scoring.
// ----------------------------------------------------------------------------
module tb_exotic_option_path_payoff_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import eopp_pkg::*;

  // Kind codes that the block must treat as unused (zero payoff, no knock).
  localparam logic [KindW-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KindW-1:0] KIND_SPARE_7 = 3'd7;

  // Every drain waits until no predicted result is pending and then also waits
  // DrainCycles before the registers are touched.
  localparam int DrainCycles = 64;
  // Length of the receiver hold-off that backs the block up into its input.
  localparam int HoldCycles  = 300;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [31:0] cfg_wdata;
  logic        sample_valid;
  logic        sample_stall;
  in_t         sample;
  logic        payoff_valid;
  logic        payoff_stall;
  out_t        payoff_data;

  int unsigned fail_count;
  int unsigned pending_payoffs;

  // Traffic shaping for the stimulus and the receiver process.
  int unsigned items_sent;
  logic [31:0] phase_center;
  bit          tx_burst;
  bit          rx_burst;
  bit          hold_long;

  exotic_option_path_payoff_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (sample_valid),
    .in_stall_o  (sample_stall),
    .in_i        (sample),
    .out_valid_o (payoff_valid),
    .out_stall_i (payoff_stall),
    .out_o       (payoff_data)
  );

  eopp_path_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (sample_valid),
    .in_stall_i   (sample_stall),
    .in_i         (sample),
    .out_valid_i  (payoff_valid),
    .out_stall_i  (payoff_stall),
    .out_i        (payoff_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_payoffs)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run as a failure.
  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] q16(int unsigned whole);
    return whole << 16;
  endfunction

  // Prices cluster around the phase center so that strikes and barriers near
  // it are crossed often; the rest are the extremes or anywhere in range.
  function automatic logic [31:0] draw_price();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return phase_center + $urandom_range(0, 262144) - 32'd131072;
    endcase
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return phase_center + $urandom_range(0, 262144) - 32'd131072;
    endcase
  endfunction

  // One input transaction. The call returns right after the accepting edge and
  // leaves valid high, so back-to-back samples never drop valid in between.
  task automatic send_sample(logic [31:0] price, logic first, logic last);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid      = 1'b1;
    sample.price      = price;
    sample.path_first = first;
    sample.path_last  = last;
    do @(posedge clk); while (sample_stall);
    items_sent++;
  endtask

  // Stop offering samples, let every predicted payoff come out, and give the
  // block time to finish any work that produces no result.
  task automatic settle_block();
    @(negedge clk);
    sample_valid = 1'b0;
    while (pending_payoffs != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_option(logic [KindW-1:0] kind, logic [31:0] strike,
                                logic [31:0] barrier);
    settle_block();
    write_reg(CFG_OPTION_KIND, 32'(kind));
    write_reg(CFG_STRIKE, strike);
    write_reg(CFG_BARRIER, barrier);
    end_writes();
  endtask

  // Mostly well-formed paths with random content; about a fifth of the picks
  // are single-sample paths or single samples with random path marks.
  task automatic run_random_phase(int unsigned n_items, bit squeeze);
    int unsigned      stop_at;
    int unsigned      hops;
    logic [KindW-1:0] kind;
    phase_center = $urandom;
    if ($urandom_range(0, 19) == 0) kind = KindW'($urandom_range(6, 7));
    else kind = KindW'($urandom_range(0, 5));
    program_option(kind, pick_level(), pick_level());
    tx_burst  = squeeze || ($urandom_range(0, 3) == 0);
    rx_burst  = ($urandom_range(0, 3) == 0);
    hold_long = squeeze;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: send_sample(draw_price(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1: send_sample(draw_price(), 1'b1, 1'b1);
        default: begin
          hops = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
          send_sample(draw_price(), 1'b1, 1'b0);
          repeat (hops) send_sample(draw_price(), 1'b0, 1'b0);
          send_sample(draw_price(), 1'b0, 1'b1);
        end
      endcase
    end
  endtask

  // Receiver: per result it draws a stall length, and on request it holds off
  // for a long stretch so the block backs up and stalls its input.
  initial begin : receiver
    int unsigned hold;
    payoff_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        @(negedge clk);
        payoff_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        payoff_stall = 1'b0;
        hold_long    = 1'b0;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        payoff_stall = (hold != 0);
        if (hold != 0) begin
          repeat (hold) @(negedge clk);
          payoff_stall = 1'b0;
        end
      end
      do @(posedge clk); while (!(payoff_valid && !payoff_stall));
    end
  end

  initial begin : stimulus
    logic [31:0] base;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_OPTION_KIND;
    cfg_wdata    = '0;
    sample_valid = 1'b0;
    sample       = '0;
    items_sent   = 0;
    phase_center = '0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    hold_long    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration is an Asian call with zero strike. The first path
    // has no start mark and continues from the reset state; then a lone
    // sample marked both first and last must come back as a bad path.
    send_sample(q16(100), 1'b0, 1'b0);
    send_sample(32'h0030_0001, 1'b0, 1'b1);
    send_sample('1, 1'b1, 1'b1);

    // Asian put against the largest strike, with both price extremes.
    program_option(KIND_ASIAN_PUT, '1, '0);
    send_sample('0, 1'b1, 1'b0);
    send_sample('1, 1'b0, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    send_sample(32'h1234_5678, 1'b0, 1'b1);

    // Down-and-out: a clean path, a knock on a price equal to the barrier,
    // and a start price below the barrier that also ends the path.
    program_option(KIND_DOWN_OUT, q16(10), q16(50));
    send_sample(q16(60), 1'b1, 1'b0);
    send_sample(q16(70), 1'b0, 1'b0);
    send_sample(q16(80), 1'b0, 1'b1);
    send_sample(q16(60), 1'b1, 1'b0);
    send_sample(q16(50), 1'b0, 1'b0);
    send_sample(q16(80), 1'b0, 1'b1);
    send_sample(q16(40), 1'b1, 1'b1);

    // Up-and-out: a knock at the barrier itself, then a final price just below it.
    program_option(KIND_UP_OUT, q16(10), q16(100));
    send_sample(q16(90), 1'b1, 1'b0);
    send_sample(q16(100), 1'b0, 1'b0);
    send_sample(q16(95), 1'b0, 1'b1);
    send_sample(q16(90), 1'b1, 1'b0);
    send_sample(q16(99), 1'b0, 1'b1);

    // Floating-strike lookbacks across the whole price range.
    program_option(KIND_LB_CALL, '0, '0);
    send_sample(q16(50), 1'b1, 1'b0);
    send_sample(q16(30), 1'b0, 1'b0);
    send_sample('1, 1'b0, 1'b1);
    program_option(KIND_LB_PUT, '1, '1);
    send_sample('0, 1'b1, 1'b0);
    send_sample('1, 1'b0, 1'b0);
    send_sample(32'd5, 1'b0, 1'b1);

    // Unused kind codes give a zero payoff and never report a knock.
    program_option(KIND_SPARE_6, '0, '0);
    send_sample(q16(1), 1'b1, 1'b0);
    send_sample(q16(2), 1'b0, 1'b1);

    // A knock taken under down-and-out survives a switch to lookback call
    // made while the path is still open.
    program_option(KIND_DOWN_OUT, '0, '1);
    send_sample(q16(7), 1'b1, 1'b0);
    settle_block();
    write_reg(CFG_OPTION_KIND, 32'(KIND_LB_CALL));
    end_writes();
    send_sample(q16(9), 1'b0, 1'b1);

    // A path longer than the step limit: the tail of large prices would pull
    // the average up if it were still counted.
    base = $urandom_range(0, 32'h7FFF_FFFF);
    program_option(KIND_ASIAN_CALL, base, '0);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    send_sample(base, 1'b1, 1'b0);
    repeat (MaxSteps) send_sample(base + $urandom_range(0, 1000), 1'b0, 1'b0);
    repeat (6) send_sample('1, 1'b0, 1'b0);
    send_sample('1, 1'b0, 1'b1);
    program_option(KIND_SPARE_7, '1, '1);
    send_sample('1, 1'b1, 1'b0);
    send_sample('0, 1'b0, 1'b1);

    // Random configurations and traffic; the third phase also runs the long
    // receiver hold-off while samples keep coming back to back.
    for (int phase = 0; phase < 8; phase++) begin
      run_random_phase(206, phase == 2);
    end

    settle_block();
    if (fail_count == 0 && pending_payoffs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
